### src/assert_macros.svh
// Assertion macros for the RTL of the fixed-point ALU.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### src/fpa_pkg.sv
// Package with the operation codes and fixed constants of the fixed-point ALU.
package fpa_pkg;

  // Operation codes carried by each input word.
  typedef enum logic [4:0] {
    OP_ADD        = 5'd0,
    OP_SUB        = 5'd1,
    OP_MUL        = 5'd2,
    OP_DIV        = 5'd3,
    OP_GT         = 5'd4,
    OP_LT         = 5'd5,
    OP_GE         = 5'd6,
    OP_LE         = 5'd7,
    OP_EQ         = 5'd8,
    OP_NE         = 5'd9,
    OP_MIN        = 5'd10,
    OP_MAX        = 5'd11,
    OP_INC        = 5'd12,
    OP_DEC        = 5'd13,
    OP_FROM_INT   = 5'd14,
    OP_FROM_FLOAT = 5'd15,
    OP_TO_FLOAT   = 5'd16,
    OP_TO_INT     = 5'd17
  } op_t;

  // IEEE single constants.
  localparam logic [7:0]  EXP_ALL_ONES = 8'hFF;
  localparam logic [10:0] EXP_BIAS_MANT = 11'd150;
  localparam logic [8:0]  EXP_BIAS = 9'd127;

  // Saturation limits of the 32-bit raw value.
  localparam logic [31:0] RAW_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] RAW_MIN = 32'h8000_0000;

endpackage

### src/fixed_point_alu_q24_8_top.sv
// Pipelined Q24.8 fixed-point ALU with float and integer conversions.
//
// Usage: one input word carries operation, operand_a, operand_b, int_value
// and float_value; it is taken at a clock edge where in_valid is high and
// in_stall is low. Each input word yields exactly one output word, shown on
// out_valid with result_raw, compare_true, float_result, int_result and
// divide_by_zero, and taken at an edge where out_valid is high and out_stall
// is low. Words leave in the order they entered.
// The pipeline has four front stages for decode, multiply and the float
// conversions, one stage for each of the 32 + FRAC_BITS quotient bits of
// the restoring divider, and one output stage. The divider chain sets that
// depth. Throughput is one word per cycle while out_stall is low.
// Each stage moves forward whenever the stage after it is empty or moving,
// so bubbles close up while the receiver stalls; in_stall rises only when
// every stage holds a word and out_stall is high.
// Reset (rst, synchronous, active high) empties the pipeline; no word is
// lost or repeated across a stall.
`include "assert_macros.svh"

module fixed_point_alu_q24_8_top
  import fpa_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [4:0]         operation,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  input  logic signed [31:0] int_value,
  input  logic [31:0]        float_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] result_raw,
  output logic               compare_true,
  output logic [31:0]        float_result,
  output logic signed [23:0] int_result,
  output logic               divide_by_zero
);

  localparam int NUMW      = 32 + FRAC_BITS;
  localparam int DIV_FIRST = 4;
  localparam int STAGES    = DIV_FIRST + NUMW + 1;
  localparam int LAST      = STAGES - 1;

  // Record carried by every pipeline stage.
  typedef struct packed {
    op_t                op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [31:0]        iv;
    logic signed [63:0] prod;
    logic               qneg;
    logic [NUMW-1:0]    num;
    logic [31:0]        den;
    logic [31:0]        rem;
    logic [NUMW-1:0]    quo;
    logic               ff_sign;
    logic               ff_nan;
    logic               ff_inf;
    logic [23:0]        ff_m;
    logic signed [10:0] ff_s;
    logic [32:0]        ff_mag;
    logic               tf_sign;
    logic [31:0]        tf_mag;
    logic [4:0]         tf_p;
    logic [31:0]        tf_norm;
    logic [31:0]        res;
    logic               cmp;
    logic [31:0]        fres;
    logic [23:0]        ires;
    logic               dz;
  } stage_t;

  stage_t st   [STAGES];
  stage_t st_next [STAGES];
  logic   vld  [STAGES];
  logic   free [STAGES];
  logic   data_zero;
  logic [3:0] kind_flags;

  // A stage may load when it is empty or its word moves on.
  always_comb begin
    free[LAST] = !vld[LAST] || !out_stall;
    for (int k = LAST - 1; k >= 0; k--) begin
      free[k] = !vld[k] || free[k+1];
    end
  end

  assign in_stall = !free[0];

  // Stage 0: decode, operand magnitudes, multiply and float field split.
  always_comb begin
    logic [31:0] a_mag;
    logic [31:0] b_mag;
    logic [7:0]  fex;
    logic [22:0] ffrac;
    logic [10:0] exe;
    st_next[0]         = '0;
    a_mag           = operand_a[31] ? 32'(-operand_a) : operand_a;
    b_mag           = operand_b[31] ? 32'(-operand_b) : operand_b;
    fex             = float_value[30:23];
    ffrac           = float_value[22:0];
    exe             = (fex == 8'd0) ? 11'd1 : {3'b0, fex};
    st_next[0].op      = op_t'(operation);
    st_next[0].a       = operand_a;
    st_next[0].b       = operand_b;
    st_next[0].iv      = int_value;
    st_next[0].prod    = operand_a * operand_b;
    st_next[0].qneg    = operand_a[31] ^ operand_b[31];
    st_next[0].num     = {a_mag, {FRAC_BITS{1'b0}}};
    st_next[0].den     = b_mag;
    st_next[0].ff_sign = float_value[31];
    st_next[0].ff_nan  = (fex == EXP_ALL_ONES) && (ffrac != 23'd0);
    st_next[0].ff_inf  = (fex == EXP_ALL_ONES) && (ffrac == 23'd0);
    st_next[0].ff_m    = (fex == 8'd0) ? {1'b0, ffrac} : {1'b1, ffrac};
    st_next[0].ff_s    = $signed(exe - EXP_BIAS_MANT + 11'(FRAC_BITS));
    st_next[0].tf_sign = operand_a[31];
    st_next[0].tf_mag  = a_mag;
  end

  // Stage 1: simple results, comparisons, float scaling, leading one search.
  always_comb begin
    logic signed [31:0] sra;
    logic [55:0]        sh_up;
    logic [25:0]        rnd;
    logic [10:0]        k;
    st_next[1] = st[0];
    sra     = st[0].a >>> FRAC_BITS;
    sh_up   = '0;
    rnd     = '0;
    k       = '0;
    case (st[0].op)
      OP_ADD:      st_next[1].res = st[0].a + st[0].b;
      OP_SUB:      st_next[1].res = st[0].a - st[0].b;
      OP_MUL:      st_next[1].res = st[0].prod[FRAC_BITS +: 32];
      OP_DIV:      st_next[1].dz = (st[0].b == 32'sd0);
      OP_GT:       st_next[1].cmp = st[0].a > st[0].b;
      OP_LT:       st_next[1].cmp = st[0].a < st[0].b;
      OP_GE:       st_next[1].cmp = st[0].a >= st[0].b;
      OP_LE:       st_next[1].cmp = st[0].a <= st[0].b;
      OP_EQ:       st_next[1].cmp = st[0].a == st[0].b;
      OP_NE:       st_next[1].cmp = st[0].a != st[0].b;
      OP_MIN:      st_next[1].res = (st[0].a < st[0].b) ? st[0].a : st[0].b;
      OP_MAX:      st_next[1].res = (st[0].a > st[0].b) ? st[0].a : st[0].b;
      OP_INC:      st_next[1].res = st[0].a + 32'sd1;
      OP_DEC:      st_next[1].res = st[0].a - 32'sd1;
      OP_FROM_INT: st_next[1].res = st[0].iv << FRAC_BITS;
      OP_TO_INT:   st_next[1].ires = sra[23:0];
      default:     st_next[1].res = '0;
    endcase

    // Scale the float mantissa, rounding half away from zero on the way down.
    if (st[0].ff_s >= 0) begin
      if (st[0].ff_s > 11'sd32) begin
        st_next[1].ff_mag = (st[0].ff_m != 24'd0) ? 33'h1_0000_0000 : 33'd0;
      end else begin
        sh_up = {32'd0, st[0].ff_m} << st[0].ff_s[5:0];
        st_next[1].ff_mag = (sh_up > 56'h1_0000_0000) ? 33'h1_0000_0000 : sh_up[32:0];
      end
    end else begin
      k = 11'(-st[0].ff_s);
      if (k > 11'd25) begin
        st_next[1].ff_mag = '0;
      end else begin
        rnd = ({2'b0, st[0].ff_m} + (26'd1 << (k[4:0] - 5'd1))) >> k[4:0];
        st_next[1].ff_mag = {7'd0, rnd};
      end
    end

    // Position of the leading one of the magnitude.
    st_next[1].tf_p = '0;
    for (int i = 0; i < 32; i++) begin
      if (st[0].tf_mag[i]) begin
        st_next[1].tf_p = 5'(i);
      end
    end
  end

  // Stage 2: float to fixed saturation and normalization for fixed to float.
  always_comb begin
    logic [32:0] lim;
    st_next[2] = st[1];
    lim     = '0;
    if (st[1].op == OP_FROM_FLOAT) begin
      if (st[1].ff_nan) begin
        st_next[2].res = '0;
      end else if (st[1].ff_inf) begin
        st_next[2].res = st[1].ff_sign ? RAW_MIN : RAW_MAX;
      end else if (st[1].ff_sign) begin
        lim = (st[1].ff_mag > {1'b0, RAW_MIN}) ? {1'b0, RAW_MIN} : st[1].ff_mag;
        st_next[2].res = 32'(-lim[31:0]);
      end else begin
        st_next[2].res = (st[1].ff_mag > {1'b0, RAW_MAX}) ? RAW_MAX : st[1].ff_mag[31:0];
      end
    end
    st_next[2].tf_norm = st[1].tf_mag << (5'd31 - st[1].tf_p);
  end

  // Stage 3: round to nearest even and pack the single.
  always_comb begin
    logic [23:0] mant;
    logic        up;
    logic [24:0] sum;
    logic [8:0]  ex;
    st_next[3] = st[2];
    mant    = st[2].tf_norm[31:8];
    up      = st[2].tf_norm[7] && ((|st[2].tf_norm[6:0]) || mant[0]);
    sum     = {1'b0, mant} + {24'd0, up};
    ex      = {4'd0, st[2].tf_p} + EXP_BIAS - 9'(FRAC_BITS) + {8'd0, sum[24]};
    if (st[2].op == OP_TO_FLOAT && st[2].tf_mag != 32'd0) begin
      st_next[3].fres = {st[2].tf_sign, ex[7:0], sum[22:0]};
    end
  end

  // Restoring divider: one quotient bit per stage.
  for (genvar j = DIV_FIRST; j < DIV_FIRST + NUMW; j++) begin : g_div
    always_comb begin
      logic [32:0] trial;
      logic        bit_q;
      st_next[j] = st[j-1];
      trial   = {st[j-1].rem, st[j-1].num[NUMW-1]};
      bit_q   = trial >= {1'b0, st[j-1].den};
      st_next[j].rem = bit_q ? 32'(trial - {1'b0, st[j-1].den}) : trial[31:0];
      st_next[j].quo = {st[j-1].quo[NUMW-2:0], bit_q};
      st_next[j].num = st[j-1].num << 1;
    end
  end

  // Output stage: signed quotient for divide.
  always_comb begin
    st_next[LAST] = st[LAST-1];
    if (st[LAST-1].op == OP_DIV && !st[LAST-1].dz) begin
      st_next[LAST].res = st[LAST-1].qneg ? 32'(-st[LAST-1].quo[31:0])
                                       : st[LAST-1].quo[31:0];
    end
  end

  // Stage registers advance independently as space frees up.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (free[0]) begin
      vld[0] <= in_valid;
    end
    if (free[0]) begin
      st[0] <= st_next[0];
    end
    for (int k = 1; k < STAGES; k++) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (free[k]) begin
        vld[k] <= vld[k-1];
      end
      if (free[k]) begin
        st[k] <= st_next[k];
      end
    end
  end

  assign out_valid      = vld[LAST];
  assign result_raw     = st[LAST].res;
  assign compare_true   = st[LAST].cmp;
  assign float_result   = st[LAST].fres;
  assign int_result     = st[LAST].ires;
  assign divide_by_zero = st[LAST].dz;

  // Helper terms for the output word checks.
  assign data_zero  = (result_raw == 32'sd0) && (float_result == 32'd0);
  assign kind_flags = {compare_true, divide_by_zero, float_result != 32'd0,
                       int_result != 24'sd0};

  `ASSERT_IMPLIES(a_stall_full, in_stall, out_valid && out_stall, "input stalled with room")
  `ASSERT_IMPLIES(a_dz_zero, out_valid && divide_by_zero, result_raw == 32'sd0, "dz result set")
  `ASSERT_IMPLIES(a_cmp_only, out_valid && compare_true, data_zero, "compare word has data")
  `ASSERT_IMPLIES(a_one_kind, out_valid, $onehot0(kind_flags), "output word mixes kinds")

endmodule
